### rtl/core/knob_pickup_and_step_quantizer_macros.svh
// assertion helpers used by the checker file
`ifndef KNOB_PICKUP_AND_STEP_QUANTIZER_MACROS_SVH
`define KNOB_PICKUP_AND_STEP_QUANTIZER_MACROS_SVH

// same-cycle implication, checked out of reset
`define KPSQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kpsq check failed");

// next-cycle implication, checked out of reset
`define KPSQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kpsq check failed");

`endif

### rtl/core/kpsq_pkg.sv
package kpsq_pkg;

    localparam int NUM_KNOBS = 9;
    localparam int KNOB_AW   = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;

    localparam int VAL_W     = 12;
    localparam int KNOB_W    = 4;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam logic [11:0] SPREAD_DIV  = 12'd683;
    localparam logic [11:0] SPREAD_HALF = 12'd341;
    localparam logic [11:0] SCALE_HALF  = 12'd256;
    localparam logic [3:0]  STEP_NONE   = 4'd15;

    localparam logic [11:0] PICKUP_RST = 12'd150;
    localparam logic [8:0]  SPREAD_MARGIN_RST = 9'd200;
    localparam logic [7:0]  SCALE_MARGIN_RST  = 8'd100;
    localparam logic [3:0]  SPREAD_KNOB_RST   = 4'd5;
    localparam logic [3:0]  SCALE_KNOB_RST    = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PICKUP        = 3'd0,
        REG_SPREAD_MARGIN = 3'd1,
        REG_SCALE_MARGIN  = 3'd2,
        REG_SPREAD_KNOB   = 3'd3,
        REG_SCALE_KNOB    = 3'd4
    } t_cfg_idx;

    // per-knob entry held in the knob memory
    typedef struct packed {
        logic [VAL_W-1:0] ref_rd;
        logic [VAL_W-1:0] tracked;
        logic             armed;
    } t_knob_ent;

    // update request towards the quantizers
    typedef struct packed {
        logic             spread_en;
        logic             scale_en;
        logic             load;
        logic [VAL_W-1:0] value;
    } t_quant_req;

    typedef struct packed {
        logic [VAL_W-1:0]  spread_center;
        logic [STEP_W-1:0] spread_step;
        logic [VAL_W-1:0]  scale_center;
        logic [STEP_W-1:0] scale_step;
    } t_quant_st;

    // value / 683 for a 12-bit value, by threshold compares
    function automatic logic [2:0] spread_quot(input logic [VAL_W-1:0] v);
        logic [2:0] q;
        if (v >= 12'(SPREAD_DIV * 5))      q = 3'd5;
        else if (v >= 12'(SPREAD_DIV * 4)) q = 3'd4;
        else if (v >= 12'(SPREAD_DIV * 3)) q = 3'd3;
        else if (v >= 12'(SPREAD_DIV * 2)) q = 3'd2;
        else if (v >= SPREAD_DIV)          q = 3'd1;
        else                               q = 3'd0;
        return q;
    endfunction

    // step * 683
    function automatic logic [VAL_W-1:0] spread_base(input logic [2:0] q);
        logic [VAL_W-1:0] b;
        case (q)
            3'd1:    b = SPREAD_DIV;
            3'd2:    b = 12'(SPREAD_DIV * 2);
            3'd3:    b = 12'(SPREAD_DIV * 3);
            3'd4:    b = 12'(SPREAD_DIV * 4);
            3'd5:    b = 12'(SPREAD_DIV * 5);
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/knob_pickup_and_step_quantizer.sv
// an accepted request passes through stage 1, alongside the knob memory read, then the output
// registers; throughput: one request per cycle unless the output is held back; the knob memory
// is read on accept and written as the request leaves stage 1, with a same-knob bypass
// reset: synchronous, active low; clears all knob entries to zero through
// per-entry valid bits, so there is no clearing pass and input is taken at once
module knob_pickup_and_step_quantizer
    import kpsq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [KNOB_W-1:0]    i_knob,
    input  logic [VAL_W-1:0]     i_sample,
    input  logic [VAL_W-1:0]     i_preset_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KNOB_W-1:0]    o_knob_id,
    output logic [VAL_W-1:0]     o_knob_value,
    output logic                 o_knob_armed,
    output logic [VAL_W-1:0]     o_spread_center,
    output logic [STEP_W-1:0]    o_spread_step,
    output logic [VAL_W-1:0]     o_scale_center,
    output logic [STEP_W-1:0]    o_scale_step
);

    logic [11:0] r_pickup;
    logic [8:0]  r_spread_margin;
    logic [7:0]  r_scale_margin;
    logic [3:0]  r_spread_knob;
    logic [3:0]  r_scale_knob;

    logic              r_s1_vld;
    logic              r_s1_op;
    logic              r_s1_inrng;
    logic [KNOB_W-1:0] r_s1_knob;
    logic [VAL_W-1:0]  r_s1_sample;
    logic [VAL_W-1:0]  r_s1_pv;

    logic              r_out_vld;
    logic [KNOB_W-1:0] r_out_knob;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_armed;
    t_quant_st         r_out_q;

    logic        in_acc;
    logic        s1_adv;
    logic        in_rng;
    t_knob_ent   ent;
    t_knob_ent   wr_ent;
    logic [11:0] ref_gap;
    logic        arm_new;
    t_quant_req  qreq;
    t_quant_st   q_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pickup        <= PICKUP_RST;
            r_spread_margin <= SPREAD_MARGIN_RST;
            r_scale_margin  <= SCALE_MARGIN_RST;
            r_spread_knob   <= SPREAD_KNOB_RST;
            r_scale_knob    <= SCALE_KNOB_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PICKUP:        r_pickup        <= i_cfg_wdata;
                REG_SPREAD_MARGIN: r_spread_margin <= i_cfg_wdata[8:0];
                REG_SCALE_MARGIN:  r_scale_margin  <= i_cfg_wdata[7:0];
                REG_SPREAD_KNOB:   r_spread_knob   <= i_cfg_wdata[3:0];
                REG_SCALE_KNOB:    r_scale_knob    <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_rng     = {1'b0, i_knob} < 5'(NUM_KNOBS);

    kpsq_knob_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc && in_rng),
        .i_rd_addr (i_knob[KNOB_AW-1:0]),
        .i_wr_en   (s1_adv && r_s1_inrng),
        .i_wr_addr (r_s1_knob[KNOB_AW-1:0]),
        .i_wr_data (wr_ent),
        .o_rd_data (ent)
    );

    // pickup: arm once the reading leaves the reference by more than the threshold
    always_comb begin
        ref_gap = (r_s1_sample >= ent.ref_rd) ? (r_s1_sample - ent.ref_rd)
                                              : (ent.ref_rd - r_s1_sample);
        arm_new = ent.armed || (ref_gap > r_pickup);
        if (r_s1_op) begin
            wr_ent.ref_rd  = r_s1_sample;
            wr_ent.tracked = r_s1_pv;
            wr_ent.armed   = 1'b0;
        end else begin
            wr_ent.ref_rd  = ent.ref_rd;
            wr_ent.tracked = arm_new ? r_s1_sample : ent.tracked;
            wr_ent.armed   = arm_new;
        end
        qreq.spread_en = r_s1_inrng && (r_s1_knob == r_spread_knob);
        qreq.scale_en  = r_s1_inrng && (r_s1_knob == r_scale_knob);
        qreq.load      = r_s1_op;
        qreq.value     = wr_ent.tracked;
    end

    kpsq_quant u_quant (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_upd           (s1_adv),
        .i_req           (qreq),
        .i_spread_margin (r_spread_margin),
        .i_scale_margin  (r_scale_margin),
        .o_next          (q_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op     <= i_op;
            r_s1_inrng  <= in_rng;
            r_s1_knob   <= i_knob;
            r_s1_sample <= i_sample;
            r_s1_pv     <= i_preset_value;
        end
        if (s1_adv) begin
            r_out_knob  <= r_s1_knob;
            r_out_value <= r_s1_inrng ? wr_ent.tracked : '0;
            r_out_armed <= r_s1_inrng && wr_ent.armed;
            r_out_q     <= q_next;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_knob_id       = r_out_knob;
    assign o_knob_value    = r_out_value;
    assign o_knob_armed    = r_out_armed;
    assign o_spread_center = r_out_q.spread_center;
    assign o_spread_step   = r_out_q.spread_step;
    assign o_scale_center  = r_out_q.scale_center;
    assign o_scale_step    = r_out_q.scale_step;

endmodule

### rtl/core/kpsq_knob_mem.sv
module kpsq_knob_mem
    import kpsq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [KNOB_AW-1:0] i_rd_addr,
    input  logic               i_wr_en,
    input  logic [KNOB_AW-1:0] i_wr_addr,
    input  t_knob_ent          i_wr_data,
    output t_knob_ent          o_rd_data
);

    t_knob_ent             mem [NUM_KNOBS];
    logic [NUM_KNOBS-1:0]  r_vld;
    t_knob_ent             r_rd_data;
    logic                  r_rd_vld;
    logic                  r_fwd;
    t_knob_ent             r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
                // write to the same entry in the same cycle wins over the stale read
                r_fwd    <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    // entries never written read as zero
    always_comb begin
        if (r_fwd) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

### rtl/core/kpsq_quant.sv
module kpsq_quant
    import kpsq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_upd,
    input  t_quant_req i_req,
    input  logic [8:0] i_spread_margin,
    input  logic [7:0] i_scale_margin,
    output t_quant_st  o_next
);

    t_quant_st   r_st;
    logic [1:0]  r_force;
    t_quant_st   n_st;
    logic [1:0]  n_force;

    logic [2:0]        sp_q;
    logic [VAL_W-1:0]  sp_diff;
    logic [9:0]        sp_r;
    logic [10:0]       sp_sum;
    logic              sp_inside;
    logic [2:0]        sc_q;
    logic [8:0]        sc_r;
    logic [9:0]        sc_sum;
    logic              sc_inside;

    always_comb begin
        sp_q      = spread_quot(i_req.value);
        sp_diff   = i_req.value - spread_base(sp_q);
        sp_r      = sp_diff[9:0];
        sp_sum    = {1'b0, sp_r} + {2'b00, i_spread_margin};
        sp_inside = (sp_r > {1'b0, i_spread_margin}) && (sp_sum < 11'(SPREAD_DIV))
                    && ({1'b0, sp_q} != r_st.spread_step);

        sc_q      = i_req.value[11:9];
        sc_r      = i_req.value[8:0];
        sc_sum    = {1'b0, sc_r} + {2'b00, i_scale_margin};
        sc_inside = (sc_r > {1'b0, i_scale_margin}) && (sc_sum < 10'd512)
                    && ({1'b0, sc_q} != r_st.scale_step);

        n_st    = r_st;
        n_force = r_force;
        if (i_req.spread_en) begin
            if (sp_inside || i_req.load || r_force[0]) begin
                n_st.spread_center = spread_base(sp_q) + SPREAD_HALF;
                n_st.spread_step   = {1'b0, sp_q};
            end
            if (!i_req.load) begin
                n_force[0] = 1'b0;
            end
        end
        if (i_req.scale_en) begin
            if (sc_inside || i_req.load || r_force[1]) begin
                n_st.scale_center = {sc_q, SCALE_HALF[8:0]};
                n_st.scale_step   = {1'b0, sc_q};
            end
            if (!i_req.load) begin
                n_force[1] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.spread_center <= '0;
            r_st.spread_step   <= STEP_NONE;
            r_st.scale_center  <= '0;
            r_st.scale_step    <= STEP_NONE;
            r_force            <= 2'b11;
        end else if (i_upd) begin
            r_st    <= n_st;
            r_force <= n_force;
        end
    end

    assign o_next = n_st;

endmodule

### rtl/core/kpsq_checker.sv
`include "knob_pickup_and_step_quantizer_macros.svh"

module kpsq_checker
    import kpsq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [KNOB_W-1:0]    o_knob_id,
    input logic [VAL_W-1:0]     o_knob_value,
    input logic                 o_knob_armed,
    input logic [VAL_W-1:0]     o_spread_center,
    input logic [STEP_W-1:0]    o_spread_step,
    input logic [VAL_W-1:0]     o_scale_center,
    input logic [STEP_W-1:0]    o_scale_step
);

    // a held result keeps its payload
    `KPSQ_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_knob_id) && $stable(o_knob_value) && $stable(o_spread_step) && $stable(o_scale_step))

    // input stalls only behind a held result
    `KPSQ_ASSERT_NOW(a_in_stall, i_in_valid && !o_in_ready, o_out_valid && !i_out_ready)

    // a knob outside the bank reports nothing of its own
    `KPSQ_ASSERT_NOW(a_knob_oor, o_out_valid && ({1'b0, o_knob_id} >= 5'(NUM_KNOBS)), (o_knob_value == '0) && !o_knob_armed)

    // spread centre always matches its step
    `KPSQ_ASSERT_NOW(a_spread_ctr, o_out_valid, ((o_spread_step == STEP_NONE) && (o_spread_center == '0)) || ((o_spread_step <= 4'd5) && (o_spread_center == 12'(spread_base(o_spread_step[2:0]) + SPREAD_HALF))))

    // scale centre always matches its step
    `KPSQ_ASSERT_NOW(a_scale_ctr, o_out_valid, ((o_scale_step == STEP_NONE) && (o_scale_center == '0)) || ((o_scale_step <= 4'd7) && (o_scale_center == {o_scale_step[2:0], SCALE_HALF[8:0]})))

endmodule

bind knob_pickup_and_step_quantizer kpsq_checker u_kpsq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_knob_id       (o_knob_id),
    .o_knob_value    (o_knob_value),
    .o_knob_armed    (o_knob_armed),
    .o_spread_center (o_spread_center),
    .o_spread_step   (o_spread_step),
    .o_scale_center  (o_scale_center),
    .o_scale_step    (o_scale_step)
);
